FILE: hdl/mbsp_pkg.sv
// ============================================================================
// MIDI byte stream parser package
// Shared types, codes and result builders for the parser, its top level
// and the port checker.
// ============================================================================
`default_nettype none

package mbsp_pkg;

   // Result kinds as they appear on the kind field.
   localparam logic [3:0] KIND_NOTE       = 4'd0;
   localparam logic [3:0] KIND_POLY       = 4'd1;
   localparam logic [3:0] KIND_CONTROL    = 4'd2;
   localparam logic [3:0] KIND_PROGRAM    = 4'd3;
   localparam logic [3:0] KIND_CHAN_PRESS = 4'd4;
   localparam logic [3:0] KIND_BEND       = 4'd5;
   localparam logic [3:0] KIND_REALTIME   = 4'd6;
   localparam logic [3:0] KIND_TIMECODE   = 4'd7;
   localparam logic [3:0] KIND_SYSEX_BYTE = 4'd8;
   localparam logic [3:0] KIND_SYSEX_END  = 4'd9;
   localparam logic [3:0] KIND_SYSEX_ABORT = 4'd10;

   // Status and data byte codes that steer the parser.
   localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
   localparam logic [7:0] BYTE_QUARTER     = 8'hF1;
   localparam logic [7:0] BYTE_SONG_POS    = 8'hF2;
   localparam logic [7:0] BYTE_SONG_SEL    = 8'hF3;
   localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
   localparam logic [7:0] BYTE_REALTIME_LO = 8'hF8;
   localparam logic [3:0] NIBBLE_SYSTEM    = 4'hF;
   localparam logic [3:0] NIBBLE_CHAN_BASE = 4'd7;
   localparam logic [6:0] DATA_REALTIME_ID = 7'h7F;
   localparam logic [6:0] DATA_FULL_FRAME  = 7'h01;

   // Full-frame field index that means no more fields are taken.
   localparam logic [2:0] FF_INDEX_SAT = 3'd7;

   // Largest number of results that one byte can cause.
   localparam int unsigned MAX_RESULTS = 3;

   typedef enum logic [3:0] {
      MODE_IDLE       = 4'd0,
      MODE_NOTE_OFF   = 4'd1,
      MODE_NOTE_ON    = 4'd2,
      MODE_POLY       = 4'd3,
      MODE_CONTROL    = 4'd4,
      MODE_PROGRAM    = 4'd5,
      MODE_CHAN_PRESS = 4'd6,
      MODE_BEND       = 4'd7,
      MODE_SX_ID      = 4'd8,
      MODE_SX_RT      = 4'd9,
      MODE_FF_ID      = 4'd10,
      MODE_FF_DATA    = 4'd11,
      MODE_SX_BYTE    = 4'd12,
      MODE_QF         = 4'd13,
      MODE_SWALLOW    = 4'd14
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_READY = 2'd0,
      PHASE_FWD   = 2'd1,
      PHASE_BWD   = 2'd2
   } phase_type;

   // One result beat.
   typedef struct packed {
      logic [3:0] kind;
      logic [3:0] chan;
      logic [6:0] first_value;
      logic [6:0] second_value;
      logic [1:0] tc_kind;
      logic [4:0] tc_hours;
      logic [7:0] tc_minutes;
      logic [7:0] tc_seconds;
      logic [7:0] tc_frames;
      logic       sysex_begin;
      logic       last;
   } result_type;

   // All results caused by one byte, in order, with their count.
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] slot;
      logic [1:0]                   count;
   } group_type;

   function automatic result_type kind_result(logic [3:0] kind);
      result_type r;
      r      = '0;
      r.kind = kind;
      return r;
   endfunction

   function automatic result_type chan_result(logic [3:0] kind, logic [3:0] chan,
                                              logic [6:0] a, logic [6:0] b);
      result_type r;
      r              = '0;
      r.kind         = kind;
      r.chan         = chan;
      r.first_value  = a;
      r.second_value = b;
      return r;
   endfunction

   function automatic result_type sysex_result(logic [6:0] value, logic begin_flag);
      result_type r;
      r             = '0;
      r.kind        = KIND_SYSEX_BYTE;
      r.first_value = value;
      r.sysex_begin = begin_flag;
      return r;
   endfunction

   function automatic result_type tc_result(logic [1:0] tkind, logic [4:0] hours,
                                            logic [7:0] minutes, logic [7:0] seconds,
                                            logic [7:0] frames);
      result_type r;
      r            = '0;
      r.kind       = KIND_TIMECODE;
      r.tc_kind    = tkind;
      r.tc_hours   = hours;
      r.tc_minutes = minutes;
      r.tc_seconds = seconds;
      r.tc_frames  = frames;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/midi_byte_stream_parser_top.sv
// ============================================================================
// MIDI byte stream parser
// Parses a received MIDI byte stream with running status, system-exclusive
// forwarding and quarter-frame time code into result beats.
// ============================================================================
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+-----------------------------------
//  req     | in        | req_valid/stall  | rx_byte
//  rsp     | out       | rsp_valid/stall  | kind, chan, values, time code,
//          |           |                  | sysex_begin, last
//
//  A byte taken is held in the input register and is decoded into the result
//  buffer when the buffer can take it; its first result beat is on the rsp
//  ports from that load on.
//  Bytes with at most one result flow at one per cycle unless rsp stalls; a
//  byte with two or three results holds the input until its extra results
//  leave, since the result buffer takes a new group only when it is emptying.
//  Synchronous reset clears the parser state and both stages.
//  A stalled result channel back-pressures the input through req_stall.
//
`default_nettype none

module midi_byte_stream_parser_top
   import mbsp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output wire logic       req_stall,
   input  wire logic [7:0] req_rx_byte,
   output wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   output wire logic [3:0] rsp_kind,
   output wire logic [3:0] rsp_chan,
   output wire logic [6:0] rsp_first_value,
   output wire logic [6:0] rsp_second_value,
   output wire logic [1:0] rsp_tc_kind,
   output wire logic [4:0] rsp_tc_hours,
   output wire logic [7:0] rsp_tc_minutes,
   output wire logic [7:0] rsp_tc_seconds,
   output wire logic [7:0] rsp_tc_frames,
   output wire logic       rsp_sysex_begin,
   output wire logic       rsp_last
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       req_take;
   logic       step;
   logic       can_load;
   group_type  group;
   result_type out_result;

   // The input register hands its byte on whenever the buffer can take it.
   assign step      = in_valid_ff && can_load;
   assign req_stall = in_valid_ff && !can_load;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Decode and parser state.
   mbsp_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .group   (group)
   );

   // Result beats out.
   mbsp_result_buffer u_buffer (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .group      (group),
      .can_load   (can_load),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (out_result)
   );

   assign rsp_kind         = out_result.kind;
   assign rsp_chan         = out_result.chan;
   assign rsp_first_value  = out_result.first_value;
   assign rsp_second_value = out_result.second_value;
   assign rsp_tc_kind      = out_result.tc_kind;
   assign rsp_tc_hours     = out_result.tc_hours;
   assign rsp_tc_minutes   = out_result.tc_minutes;
   assign rsp_tc_seconds   = out_result.tc_seconds;
   assign rsp_tc_frames    = out_result.tc_frames;
   assign rsp_sysex_begin  = out_result.sysex_begin;
   assign rsp_last         = out_result.last;

endmodule

`default_nettype wire

FILE: hdl/mbsp_decode.sv
// ============================================================================
// MIDI byte decoder
// Holds the parser state (running status, pending data byte, sysex and time
// code state) and turns one byte into its group of up to three results.
// ============================================================================
`default_nettype none

module mbsp_decode
   import mbsp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   output wire group_type  group
);

   mode_type   mode_ff, mode_in;
   logic [3:0] chan_ff, chan_in;
   logic       held_valid_ff, held_valid_in;
   logic [6:0] held_data_ff, held_data_in;
   logic       sysex_open_ff, sysex_open_in;
   logic [2:0] ff_index_ff, ff_index_in;
   phase_type  phase_ff, phase_in;
   logic [1:0] tc_kind_ff, tc_kind_in;
   logic [4:0] tc_hours_ff, tc_hours_in;
   logic [7:0] tc_minutes_ff, tc_minutes_in;
   logic [7:0] tc_seconds_ff, tc_seconds_in;
   logic [7:0] tc_frames_ff, tc_frames_in;

   logic [1:0] push_count;
   result_type [MAX_RESULTS-1:0] slots;
   logic [6:0] data;
   logic [3:0] lo;
   logic       is_realtime;
   logic       pair_zero;
   logic [3:0] pair_kind;
   logic       pair_mode;

   assign data        = rx_byte[6:0];
   assign lo          = rx_byte[3:0];
   assign is_realtime = (rx_byte >= BYTE_REALTIME_LO);

   // Two-byte channel messages share one path through the pending data byte.
   always_comb begin
      pair_mode = 1'b1;
      pair_zero = 1'b0;
      pair_kind = KIND_NOTE;
      case (mode_ff)
         MODE_NOTE_OFF: begin
            pair_zero = 1'b1;
         end
         MODE_NOTE_ON: begin
            pair_kind = KIND_NOTE;
         end
         MODE_POLY: begin
            pair_kind = KIND_POLY;
         end
         MODE_CONTROL: begin
            pair_kind = KIND_CONTROL;
         end
         MODE_BEND: begin
            pair_kind = KIND_BEND;
         end
         default: begin
            pair_mode = 1'b0;
         end
      endcase
   end

   // Next parser state. Real-time bytes match no branch and leave it alone.
   always_comb begin
      mode_in       = mode_ff;
      chan_in       = chan_ff;
      held_valid_in = held_valid_ff;
      held_data_in  = held_data_ff;
      sysex_open_in = sysex_open_ff;
      ff_index_in   = ff_index_ff;
      phase_in      = phase_ff;
      tc_kind_in    = tc_kind_ff;
      tc_hours_in   = tc_hours_ff;
      tc_minutes_in = tc_minutes_ff;
      tc_seconds_in = tc_seconds_ff;
      tc_frames_in  = tc_frames_ff;

      if (rx_byte == BYTE_SYSEX_END) begin
         sysex_open_in = 1'b0;
         mode_in       = MODE_IDLE;
      end else if (rx_byte[7] && !is_realtime) begin
         // Any other status byte first closes an open sysex run.
         if (sysex_open_ff) begin
            sysex_open_in = 1'b0;
            mode_in       = MODE_IDLE;
         end
         if (rx_byte[7:4] == NIBBLE_SYSTEM) begin
            case (rx_byte)
               BYTE_SYSEX_START: begin
                  mode_in = MODE_SX_ID;
               end
               BYTE_QUARTER: begin
                  mode_in = MODE_QF;
               end
               BYTE_SONG_POS, BYTE_SONG_SEL: begin
                  mode_in = MODE_SWALLOW;
               end
               default: begin
               end
            endcase
         end else begin
            mode_in       = mode_type'(rx_byte[7:4] - NIBBLE_CHAN_BASE);
            chan_in       = rx_byte[3:0];
            held_valid_in = 1'b0;
         end
      end else if (!rx_byte[7]) begin
         if (pair_mode) begin
            if (!held_valid_ff) begin
               held_data_in  = data;
               held_valid_in = 1'b1;
            end else begin
               held_valid_in = 1'b0;
            end
         end else begin
            case (mode_ff)
               MODE_SX_ID: begin
                  if (data == DATA_REALTIME_ID) begin
                     mode_in = MODE_SX_RT;
                  end else begin
                     sysex_open_in = 1'b1;
                     mode_in       = MODE_SX_BYTE;
                  end
               end
               MODE_SX_RT: begin
                  if (data == DATA_FULL_FRAME) begin
                     mode_in = MODE_FF_ID;
                  end else begin
                     sysex_open_in = 1'b1;
                     mode_in       = MODE_SX_BYTE;
                  end
               end
               MODE_FF_ID: begin
                  if (data == DATA_FULL_FRAME) begin
                     mode_in     = MODE_FF_DATA;
                     ff_index_in = 3'd0;
                  end else begin
                     sysex_open_in = 1'b1;
                     mode_in       = MODE_SX_BYTE;
                  end
               end
               MODE_FF_DATA: begin
                  case (ff_index_ff)
                     3'd0: begin
                        tc_kind_in  = data[6:5];
                        tc_hours_in = data[4:0];
                     end
                     3'd1: begin
                        tc_minutes_in = {1'b0, data};
                     end
                     3'd2: begin
                        tc_seconds_in = {1'b0, data};
                     end
                     3'd3: begin
                        tc_frames_in = {1'b0, data};
                     end
                     default: begin
                     end
                  endcase
                  if (ff_index_ff != FF_INDEX_SAT) begin
                     ff_index_in = ff_index_ff + 3'd1;
                  end
               end
               MODE_QF: begin
                  // Quarter-frame piece; the upper data bits select the nibble.
                  mode_in = MODE_IDLE;
                  case (data[6:4])
                     3'd0: begin
                        tc_frames_in = {tc_frames_ff[7:4], lo};
                        if (phase_ff == PHASE_BWD) begin
                           phase_in = PHASE_READY;
                        end else begin
                           phase_in = PHASE_FWD;
                        end
                     end
                     3'd1: begin
                        tc_frames_in = {lo, tc_frames_ff[3:0]};
                     end
                     3'd2: begin
                        tc_seconds_in = {tc_seconds_ff[7:4], lo};
                     end
                     3'd3: begin
                        tc_seconds_in = {lo, tc_seconds_ff[3:0]};
                     end
                     3'd4: begin
                        tc_minutes_in = {tc_minutes_ff[7:4], lo};
                     end
                     3'd5: begin
                        tc_minutes_in = {lo, tc_minutes_ff[3:0]};
                     end
                     3'd6: begin
                        tc_hours_in = {tc_hours_ff[4], lo};
                     end
                     default: begin
                        tc_hours_in = {data[0], tc_hours_ff[3:0]};
                        tc_kind_in  = data[6:5];
                        if (phase_ff == PHASE_FWD) begin
                           phase_in = PHASE_READY;
                        end else begin
                           phase_in = PHASE_BWD;
                        end
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Results of this byte, in order.
   always_comb begin
      slots      = '0;
      push_count = 2'd0;

      if (is_realtime) begin
         // Real-time bytes give a tag from 1 to 8.
         slots[0] = kind_result(KIND_REALTIME);
         slots[0].first_value = {4'd0, 3'(rx_byte[2:0] + 3'd1)} |
                                {3'd0, (rx_byte[2:0] == 3'd7), 3'd0};
         push_count = 2'd1;
      end else if (rx_byte == BYTE_SYSEX_END) begin
         if (sysex_open_ff) begin
            slots[0]   = kind_result(KIND_SYSEX_END);
            push_count = 2'd1;
         end
      end else if (rx_byte[7]) begin
         if (sysex_open_ff) begin
            slots[0]   = kind_result(KIND_SYSEX_ABORT);
            push_count = 2'd1;
         end
      end else if (pair_mode) begin
         if (held_valid_ff) begin
            slots[0] = chan_result(pair_kind, chan_ff, held_data_ff,
                                   pair_zero ? 7'd0 : data);
            push_count = 2'd1;
         end
      end else begin
         case (mode_ff)
            MODE_PROGRAM: begin
               slots[0]   = chan_result(KIND_PROGRAM, chan_ff, data, 7'd0);
               push_count = 2'd1;
            end
            MODE_CHAN_PRESS: begin
               slots[0]   = chan_result(KIND_CHAN_PRESS, chan_ff, data, 7'd0);
               push_count = 2'd1;
            end
            MODE_SX_ID: begin
               if (data != DATA_REALTIME_ID) begin
                  slots[0]   = sysex_result(data, 1'b1);
                  push_count = 2'd1;
               end
            end
            MODE_SX_RT: begin
               if (data != DATA_FULL_FRAME) begin
                  // Replay the swallowed prefix in front of this byte.
                  slots[0]   = sysex_result(DATA_REALTIME_ID, 1'b1);
                  slots[1]   = sysex_result(data, 1'b0);
                  push_count = 2'd2;
               end
            end
            MODE_FF_ID: begin
               if (data != DATA_FULL_FRAME) begin
                  slots[0]   = sysex_result(DATA_REALTIME_ID, 1'b1);
                  slots[1]   = sysex_result(DATA_FULL_FRAME, 1'b0);
                  slots[2]   = sysex_result(data, 1'b0);
                  push_count = 2'd3;
               end
            end
            MODE_SX_BYTE: begin
               slots[0]   = sysex_result(data, 1'b0);
               push_count = 2'd1;
            end
            MODE_QF: begin
               // A completed forward or backward run sends the time code.
               case (data[6:4])
                  3'd0: begin
                     if (phase_ff == PHASE_BWD) begin
                        slots[0] = tc_result(tc_kind_ff, tc_hours_ff, tc_minutes_ff,
                                             tc_seconds_ff, {tc_frames_ff[7:4], lo});
                        push_count = 2'd1;
                     end
                  end
                  3'd7: begin
                     if (phase_ff == PHASE_FWD) begin
                        slots[0] = tc_result(data[6:5], {data[0], tc_hours_ff[3:0]},
                                             tc_minutes_ff, tc_seconds_ff, tc_frames_ff);
                        push_count = 2'd1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      // Flag the final result of this byte.
      case (push_count)
         2'd1: begin
            slots[0].last = 1'b1;
         end
         2'd2: begin
            slots[1].last = 1'b1;
         end
         2'd3: begin
            slots[2].last = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign group.slot  = slots;
   assign group.count = push_count;

   // Parser state advances once for each byte taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         chan_ff       <= 4'd0;
         held_valid_ff <= 1'b0;
         held_data_ff  <= 7'd0;
         sysex_open_ff <= 1'b0;
         ff_index_ff   <= FF_INDEX_SAT;
         phase_ff      <= PHASE_READY;
         tc_kind_ff    <= 2'd0;
         tc_hours_ff   <= 5'd0;
         tc_minutes_ff <= 8'd0;
         tc_seconds_ff <= 8'd0;
         tc_frames_ff  <= 8'd0;
      end else if (step) begin
         mode_ff       <= mode_in;
         chan_ff       <= chan_in;
         held_valid_ff <= held_valid_in;
         held_data_ff  <= held_data_in;
         sysex_open_ff <= sysex_open_in;
         ff_index_ff   <= ff_index_in;
         phase_ff      <= phase_in;
         tc_kind_ff    <= tc_kind_in;
         tc_hours_ff   <= tc_hours_in;
         tc_minutes_ff <= tc_minutes_in;
         tc_seconds_ff <= tc_seconds_in;
         tc_frames_ff  <= tc_frames_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/mbsp_result_buffer.sv
// ============================================================================
// Result buffer
// Holds the group of results of one byte and hands them out one beat at a
// time, shifting the remaining results toward the output.
// ============================================================================
`default_nettype none

module mbsp_result_buffer
   import mbsp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire group_type  group,
   output wire logic       can_load,
   output wire logic       out_valid,
   input  wire logic       out_stall,
   output wire result_type out_result
);

   result_type [MAX_RESULTS-1:0] slots_ff, slots_in;
   logic [1:0] left_ff, left_in;
   logic       pop;

   assign pop        = (left_ff != 2'd0) && !out_stall;
   assign out_valid  = (left_ff != 2'd0);
   assign out_result = slots_ff[0];

   // A new group may enter once the last waiting beat leaves.
   assign can_load = (left_ff == 2'd0) || ((left_ff == 2'd1) && pop);

   // Load a new group or shift the waiting results forward.
   always_comb begin
      slots_in = slots_ff;
      left_in  = left_ff;
      if (load) begin
         slots_in = group.slot;
         left_in  = group.count;
      end else if (pop) begin
         slots_in[0] = slots_ff[1];
         slots_in[1] = slots_ff[2];
         left_in     = left_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 2'd0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
   end

endmodule

`default_nettype wire

FILE: hdl/mbsp_checker.sv
// ============================================================================
// MIDI byte stream parser port checker
// Watches the top-level ports for result ordering and handshake rules.
// ============================================================================
`default_nettype none

module mbsp_checker
   import mbsp_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [3:0] rsp_kind,
   input wire logic [3:0] rsp_chan,
   input wire logic       rsp_sysex_begin,
   input wire logic       rsp_last
);

   // No result beat is offered right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result beat shown right after reset");

   // The results of one byte leave without gaps.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside the results of one byte");

   // A stalled beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // Real-time tags, sysex end and abort are always the final result of a byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_REALTIME || rsp_kind == KIND_SYSEX_END ||
                    rsp_kind == KIND_SYSEX_ABORT) |-> rsp_last && !rsp_sysex_begin)
      else $error("real-time or sysex close not the final result");

   // Only channel messages carry a channel number.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind >= KIND_REALTIME |-> rsp_chan == 4'd0)
      else $error("channel set on a non-channel result");

endmodule

bind midi_byte_stream_parser_top mbsp_checker u_mbsp_checker (.*);

`default_nettype wire

FILE: tb/sv/midi_byte_stream_parser_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// MIDI byte stream parser testbench
// Feeds received bytes through the request channel and checks every result
// beat against a cycle-free model of the parser kept in this file. A short
// table of directed bytes comes first, then random message sequences with
// bursty input, a patterned result stall and one long result hold-off.
// ============================================================================

module midi_byte_stream_parser_top_tb;
   import mbsp_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_BYTES  = 263;
   localparam int HOLD_CYCLES   = 80;
   localparam int DIRECTED_COUNT = 37;

   // One directed byte, with a typed single-beat expectation where it is obvious.
   typedef struct packed {
      logic [7:0] rx;
      logic       typed;
      logic [3:0] want_kind;
      logic [6:0] want_first;
   } directed_row_type;

   localparam logic [11:0] UNTYPED = '0;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_stall   = 1'b0;
   wire        req_stall;
   wire        rsp_valid;
   wire  [3:0] rsp_kind;
   wire  [3:0] rsp_chan;
   wire  [6:0] rsp_first_value;
   wire  [6:0] rsp_second_value;
   wire  [1:0] rsp_tc_kind;
   wire  [4:0] rsp_tc_hours;
   wire  [7:0] rsp_tc_minutes;
   wire  [7:0] rsp_tc_seconds;
   wire  [7:0] rsp_tc_frames;
   wire        rsp_sysex_begin;
   wire        rsp_last;

   midi_byte_stream_parser_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_chan         (rsp_chan),
      .rsp_first_value  (rsp_first_value),
      .rsp_second_value (rsp_second_value),
      .rsp_tc_kind      (rsp_tc_kind),
      .rsp_tc_hours     (rsp_tc_hours),
      .rsp_tc_minutes   (rsp_tc_minutes),
      .rsp_tc_seconds   (rsp_tc_seconds),
      .rsp_tc_frames    (rsp_tc_frames),
      .rsp_sysex_begin  (rsp_sysex_begin),
      .rsp_last         (rsp_last)
   );

   always #2 clock = ~clock;

   // Stimulus store and bookkeeping.
   logic [7:0] stim_bytes[$];
   bit         stim_typed[$];
   result_type stim_want[$];
   result_type expected_results[$];
   result_type step_results[$];
   directed_row_type directed_rows [DIRECTED_COUNT];
   int total_rows     = 0;
   int bytes_accepted = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   int beats_checked  = 0;
   int timecode_beats = 0;
   int sysex_beats    = 0;
   int input_stalls   = 0;
   bit pressure_on    = 1'b0;

   // Parser model state.
   mode_type   parser_mode;
   logic [3:0] cur_chan;
   logic       held_ok;
   logic [6:0] held_val;
   logic       sx_open;
   logic [2:0] ff_idx;
   phase_type  qphase;
   logic [1:0] t_kind;
   logic [4:0] t_hours;
   logic [7:0] t_min;
   logic [7:0] t_sec;
   logic [7:0] t_frm;

   task automatic model_reset();
      parser_mode = MODE_IDLE;
      cur_chan    = '0;
      held_ok     = 1'b0;
      held_val    = '0;
      sx_open     = 1'b0;
      ff_idx      = FF_INDEX_SAT;
      qphase      = PHASE_READY;
      t_kind      = '0;
      t_hours     = '0;
      t_min       = '0;
      t_sec       = '0;
      t_frm       = '0;
   endtask

   task automatic emit_chan_msg(logic [3:0] kind, logic [6:0] a, logic [6:0] b);
      result_type r;
      r              = '0;
      r.kind         = kind;
      r.chan         = cur_chan;
      r.first_value  = a;
      r.second_value = b;
      step_results.push_back(r);
   endtask

   task automatic emit_flag(logic [3:0] kind, logic [6:0] value);
      result_type r;
      r             = '0;
      r.kind        = kind;
      r.first_value = value;
      step_results.push_back(r);
   endtask

   task automatic emit_sysex(logic [6:0] value, logic begin_flag);
      result_type r;
      r             = '0;
      r.kind        = KIND_SYSEX_BYTE;
      r.first_value = value;
      r.sysex_begin = begin_flag;
      step_results.push_back(r);
   endtask

   task automatic emit_timecode();
      result_type r;
      r            = '0;
      r.kind       = KIND_TIMECODE;
      r.tc_kind    = t_kind;
      r.tc_hours   = t_hours;
      r.tc_minutes = t_min;
      r.tc_seconds = t_sec;
      r.tc_frames  = t_frm;
      step_results.push_back(r);
   endtask

   // First data byte is held; the second completes the message.
   task automatic pair_data(logic [3:0] kind, logic [6:0] b, bit zero_second);
      if (!held_ok) begin
         held_val = b;
         held_ok  = 1'b1;
      end else begin
         emit_chan_msg(kind, held_val, zero_second ? 7'd0 : b);
         held_ok = 1'b0;
      end
   endtask

   // Quarter-frame piece: a run from piece 0 to 7, or 7 to 0, sends the time code.
   task automatic quarter_piece(logic [6:0] b);
      logic [3:0] lo;
      lo = b[3:0];
      case (b[6:4])
         3'd0: begin
            t_frm[3:0] = lo;
            if (qphase == PHASE_BWD) begin
               emit_timecode();
               qphase = PHASE_READY;
            end else begin
               qphase = PHASE_FWD;
            end
         end
         3'd1: t_frm[7:4] = lo;
         3'd2: t_sec[3:0] = lo;
         3'd3: t_sec[7:4] = lo;
         3'd4: t_min[3:0] = lo;
         3'd5: t_min[7:4] = lo;
         3'd6: t_hours[3:0] = lo;
         default: begin
            t_hours[4] = b[0];
            t_kind     = b[6:5];
            if (qphase == PHASE_FWD) begin
               emit_timecode();
               qphase = PHASE_READY;
            end else begin
               qphase = PHASE_BWD;
            end
         end
      endcase
      parser_mode = MODE_IDLE;
   endtask

   task automatic model_data(logic [6:0] b);
      case (parser_mode)
         MODE_NOTE_OFF:   pair_data(KIND_NOTE, b, 1'b1);
         MODE_NOTE_ON:    pair_data(KIND_NOTE, b, 1'b0);
         MODE_POLY:       pair_data(KIND_POLY, b, 1'b0);
         MODE_CONTROL:    pair_data(KIND_CONTROL, b, 1'b0);
         MODE_PROGRAM:    emit_chan_msg(KIND_PROGRAM, b, 7'd0);
         MODE_CHAN_PRESS: emit_chan_msg(KIND_CHAN_PRESS, b, 7'd0);
         MODE_BEND:       pair_data(KIND_BEND, b, 1'b0);
         MODE_SX_ID: begin
            if (b == DATA_REALTIME_ID) begin
               parser_mode = MODE_SX_RT;
            end else begin
               emit_sysex(b, 1'b1);
               sx_open     = 1'b1;
               parser_mode = MODE_SX_BYTE;
            end
         end
         MODE_SX_RT: begin
            if (b == DATA_FULL_FRAME) begin
               parser_mode = MODE_FF_ID;
            end else begin
               emit_sysex(DATA_REALTIME_ID, 1'b1);
               emit_sysex(b, 1'b0);
               sx_open     = 1'b1;
               parser_mode = MODE_SX_BYTE;
            end
         end
         MODE_FF_ID: begin
            if (b == DATA_FULL_FRAME) begin
               parser_mode = MODE_FF_DATA;
               ff_idx      = '0;
            end else begin
               emit_sysex(DATA_REALTIME_ID, 1'b1);
               emit_sysex(DATA_FULL_FRAME, 1'b0);
               emit_sysex(b, 1'b0);
               sx_open     = 1'b1;
               parser_mode = MODE_SX_BYTE;
            end
         end
         MODE_FF_DATA: begin
            case (ff_idx)
               3'd0: begin
                  t_kind  = b[6:5];
                  t_hours = b[4:0];
               end
               3'd1: t_min = {1'b0, b};
               3'd2: t_sec = {1'b0, b};
               3'd3: t_frm = {1'b0, b};
               default: ;
            endcase
            if (ff_idx < FF_INDEX_SAT) ff_idx = ff_idx + 3'd1;
         end
         MODE_SX_BYTE: emit_sysex(b, 1'b0);
         MODE_QF:      quarter_piece(b);
         default: ;
      endcase
   endtask

   // Works out the result beats of one accepted byte into step_results.
   task automatic predict_byte(logic [7:0] b);
      result_type r;
      step_results.delete();
      if (b >= BYTE_REALTIME_LO) begin
         emit_flag(KIND_REALTIME, {4'd0, b[2:0]} + 7'd1);
      end else if (b == BYTE_SYSEX_END) begin
         if (sx_open) begin
            emit_flag(KIND_SYSEX_END, 7'd0);
            sx_open = 1'b0;
         end
         parser_mode = MODE_IDLE;
      end else if (b[7]) begin
         // Any other status byte closes an open run first.
         if (sx_open) begin
            emit_flag(KIND_SYSEX_ABORT, 7'd0);
            sx_open     = 1'b0;
            parser_mode = MODE_IDLE;
         end
         if (b[7:4] == NIBBLE_SYSTEM) begin
            case (b)
               BYTE_SYSEX_START: parser_mode = MODE_SX_ID;
               BYTE_QUARTER:     parser_mode = MODE_QF;
               BYTE_SONG_POS, BYTE_SONG_SEL: parser_mode = MODE_SWALLOW;
               default: ;
            endcase
         end else begin
            parser_mode = mode_type'(b[7:4] - NIBBLE_CHAN_BASE);
            cur_chan    = b[3:0];
            held_ok     = 1'b0;
         end
      end else begin
         model_data(b[6:0]);
      end
      if (step_results.size() > 0) begin
         r      = step_results.pop_back();
         r.last = 1'b1;
         step_results.push_back(r);
      end
   endtask

   // Stimulus builders.
   task automatic put_byte(logic [7:0] b);
      stim_bytes.push_back(b);
      stim_typed.push_back(1'b0);
      stim_want.push_back('0);
   endtask

   task automatic maybe_realtime();
      if ($urandom_range(0, 9) == 0) put_byte(8'($urandom_range(BYTE_REALTIME_LO, 8'hFF)));
   endtask

   task automatic build_random(int target);
      int pick;
      int n;
      int sel;
      bit fwd;
      logic [2:0] piece;
      while (stim_bytes.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 28) begin
            // Channel message with running status.
            put_byte(8'($urandom_range(8'h80, 8'hEF)));
            n = $urandom_range(1, 6);
            repeat (n) begin
               maybe_realtime();
               put_byte(8'($urandom_range(0, 127)));
            end
         end else if (pick < 50) begin
            // System-exclusive run, with or without the full-frame prefix.
            put_byte(BYTE_SYSEX_START);
            sel = $urandom_range(0, 3);
            if (sel >= 1) put_byte({1'b0, DATA_REALTIME_ID});
            if (sel >= 2) put_byte({1'b0, DATA_FULL_FRAME});
            if (sel == 3) begin
               put_byte({1'b0, DATA_FULL_FRAME});
               n = $urandom_range(3, 6);
            end else begin
               n = $urandom_range(0, 5);
            end
            repeat (n) begin
               maybe_realtime();
               put_byte(8'($urandom_range(0, 127)));
            end
            sel = $urandom_range(0, 9);
            if (sel < 7) put_byte(BYTE_SYSEX_END);
            else if (sel < 9) put_byte(8'($urandom_range(8'h80, 8'hF6)));
         end else if (pick < 70) begin
            // Quarter-frame run, forward or backward, now and then broken.
            fwd = 1'($urandom_range(0, 1));
            for (int i = 0; i < 8; i++) begin
               piece = fwd ? i[2:0] : 3'(7 - i);
               if ($urandom_range(0, 11) != 0) begin
                  put_byte(BYTE_QUARTER);
                  maybe_realtime();
                  put_byte({1'b0, piece, 4'($urandom_range(0, 15))});
               end
            end
         end else if (pick < 78) begin
            put_byte($urandom_range(0, 1) ? BYTE_SONG_POS : BYTE_SONG_SEL);
            n = $urandom_range(0, 3);
            repeat (n) put_byte(8'($urandom_range(0, 127)));
         end else if (pick < 85) begin
            put_byte(8'($urandom_range(8'hF4, BYTE_SYSEX_END)));
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) put_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Compares one field of a result beat.
   task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: rsp_%s mismatch, expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Run timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d beats outstanding", $time, expected_results.size());
         $display("[midi_byte_stream_parser_top] ERROR");
         $finish;
      end
   end

   // Sender: bursts of bytes separated by random gaps.
   initial begin : byte_sender
      int burst_left;
      int gap_left;
      int cur_idx;
      logic took;
      burst_left = 0;
      gap_left   = 0;
      cur_idx    = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         took = req_valid && !req_stall;
         if (req_valid && req_stall) input_stalls++;
         if (took) begin
            predict_byte(stim_bytes[cur_idx]);
            if (stim_typed[cur_idx]) begin
               expected_results.push_back(stim_want[cur_idx]);
            end else begin
               while (step_results.size() > 0)
                  expected_results.push_back(step_results.pop_front());
            end
            bytes_accepted++;
         end
         @(negedge clock);
         if (!req_valid || took) begin
            if (bytes_accepted >= total_rows) begin
               req_valid <= 1'b0;
            end else if (gap_left > 0 && !pressure_on) begin
               gap_left--;
               req_valid <= 1'b0;
            end else begin
               cur_idx = bytes_accepted;
               req_rx_byte <= stim_bytes[cur_idx];
               req_valid   <= 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // Receiver: stall pattern that changes style, plus one long hold-off.
   initial begin : rsp_staller
      int pattern_left;
      int style;
      int hold_left;
      bit hold_done;
      logic stall_next;
      pattern_left = 0;
      style        = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && bytes_accepted >= DIRECTED_COUNT + 80) begin
            hold_done   = 1'b1;
            hold_left   = HOLD_CYCLES;
            pressure_on = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
            if (hold_left == 0) pressure_on = 1'b0;
         end else begin
            if (pattern_left == 0) begin
               style        = $urandom_range(0, 3);
               pattern_left = $urandom_range(10, 60);
            end
            pattern_left--;
            case (style)
               0: stall_next = 1'b0;
               1: stall_next = ($urandom_range(0, 3) == 0);
               2: stall_next = ($urandom_range(0, 3) != 0);
               default: stall_next = ((cycle_count % 5) < 2);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // Result checker.
   always @(posedge clock) begin : rsp_checker
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result beat, kind %0d first %0h", $time, rsp_kind,
                     rsp_first_value);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            report_field("kind", 8'(want.kind), 8'(rsp_kind));
            report_field("chan", 8'(want.chan), 8'(rsp_chan));
            report_field("first_value", 8'(want.first_value), 8'(rsp_first_value));
            report_field("second_value", 8'(want.second_value), 8'(rsp_second_value));
            report_field("tc_kind", 8'(want.tc_kind), 8'(rsp_tc_kind));
            report_field("tc_hours", 8'(want.tc_hours), 8'(rsp_tc_hours));
            report_field("tc_minutes", want.tc_minutes, rsp_tc_minutes);
            report_field("tc_seconds", want.tc_seconds, rsp_tc_seconds);
            report_field("tc_frames", want.tc_frames, rsp_tc_frames);
            report_field("sysex_begin", 8'(want.sysex_begin), 8'(rsp_sysex_begin));
            report_field("last", 8'(want.last), 8'(rsp_last));
            beats_checked++;
            if (want.kind == KIND_TIMECODE) timecode_beats++;
            if (want.kind >= KIND_SYSEX_BYTE) sysex_beats++;
         end
      end
   end

   // Main flow: build stimulus, reset, wait for everything to drain.
   initial begin : main_flow
      result_type typed_want;
      directed_rows = '{
         {BYTE_REALTIME_LO, 1'b1, KIND_REALTIME, 7'd1},
         {8'hFF, 1'b1, KIND_REALTIME, 7'd8},
         // Full-frame header and its four fields, then a close with no run open.
         {BYTE_SYSEX_START, UNTYPED},
         {1'b0, DATA_REALTIME_ID, UNTYPED},
         {1'b0, DATA_FULL_FRAME, UNTYPED},
         {1'b0, DATA_FULL_FRAME, UNTYPED},
         {8'h63, UNTYPED},
         {8'h3B, UNTYPED},
         {8'h3B, UNTYPED},
         {8'h1D, UNTYPED},
         {BYTE_SYSEX_END, UNTYPED},
         // Backward quarter-frame completion, piece 7 then piece 0.
         {BYTE_QUARTER, UNTYPED},
         {8'h7A, UNTYPED},
         {BYTE_QUARTER, UNTYPED},
         {8'h02, UNTYPED},
         // Replayed prefix, then a channel status aborts the run.
         {BYTE_SYSEX_START, UNTYPED},
         {1'b0, DATA_REALTIME_ID, UNTYPED},
         {8'h05, UNTYPED},
         {8'h9F, 1'b1, KIND_SYSEX_ABORT, 7'd0},
         {8'h00, UNTYPED},
         {8'h7F, UNTYPED},
         {8'h8A, UNTYPED},
         {8'h7F, UNTYPED},
         {8'h7F, UNTYPED},
         {8'hA0, UNTYPED},
         {8'h01, UNTYPED},
         {8'h02, UNTYPED},
         {8'hB1, UNTYPED},
         {8'h7F, UNTYPED},
         {8'h00, UNTYPED},
         {8'hC2, UNTYPED},
         {8'h55, UNTYPED},
         {8'hD3, UNTYPED},
         {8'h7F, UNTYPED},
         {8'hEF, UNTYPED},
         {8'h00, UNTYPED},
         {8'h7F, UNTYPED}
      };
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         typed_want             = '0;
         typed_want.kind        = directed_rows[i].want_kind;
         typed_want.first_value = directed_rows[i].want_first;
         typed_want.last        = 1'b1;
         stim_bytes.push_back(directed_rows[i].rx);
         stim_typed.push_back(directed_rows[i].typed);
         stim_want.push_back(typed_want);
      end
      build_random(DIRECTED_COUNT + RANDOM_BYTES);
      total_rows = stim_bytes.size();
      model_reset();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (bytes_accepted != total_rows) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d bytes and %0d result beats (%0d time code, %0d sysex).",
               total_rows, beats_checked, timecode_beats, sysex_beats);
      $display("The input was held off on %0d cycles; %0d mismatches were seen.",
               input_stalls, error_count);
      if (error_count == 0) begin
         $display("[midi_byte_stream_parser_top] OK");
      end else begin
         $display("[midi_byte_stream_parser_top] ERROR");
      end
      $finish;
   end

endmodule
